// ===== rtl/core/fat_cluster_table_allocator_macros.svh =====
// Assertion macros for the cluster table allocator.
// Used by the top level; no other dependencies.
`ifndef FAT_CLUSTER_TABLE_ALLOCATOR_MACROS_SVH
`define FAT_CLUSTER_TABLE_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define FAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define FAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/fat_pkg.sv =====
// Shared types and constants for the cluster table allocator.
// No dependencies; imported by every module of the block.
`default_nettype none
package fat_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int KW = $clog2(TABLE_ENTRIES + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // Cluster marks and limits
    localparam logic [31:0] MIN_CLUSTER = 32'd2;
    localparam logic [31:0] MAX_CLUSTER = 32'h0FFF_FFF6;
    localparam logic [31:0] BAD_MARK = 32'h0FFF_FFF7;
    localparam logic [31:0] EOC_LOW = 32'h0FFF_FFF8;
    localparam logic [31:0] EOC_MARK = 32'h0FFF_FFFF;
    localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;
    localparam logic [27:0] COUNT_MAX = 28'h0FF_FFFF | 28'hF00_0000;
    localparam logic [27:0] RESET_TOTAL = 28'd1023;

    // Request modes
    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_ALLOC = 2'd2;
    localparam logic [1:0] MODE_FREE = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_REJECT,
        OP_READ,
        OP_READ_EOC,
        OP_WRITE,
        OP_ALLOC,
        OP_FREE
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [AW-1:0]   addr;
        logic [31:0]     value;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_stat;

endpackage
`default_nettype wire

// ===== rtl/core/fat_ifs.sv =====
// Request and response channel interfaces for the cluster table allocator.
// Plain valid/ready channels; no package dependency.
`default_nettype none
interface fat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] cluster_number;
    logic [31:0] entry_value;

    modport source (output valid, output mode, output cluster_number,
                    output entry_value, input ready);
    modport sink (input valid, input mode, input cluster_number,
                  input entry_value, output ready);
endinterface

interface fat_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_data;
    logic [1:0]  status;
    logic        is_end_of_chain;
    logic        is_bad;
    logic [27:0] free_count;

    modport source (output valid, output result_data, output status,
                    output is_end_of_chain, output is_bad, output free_count,
                    input ready);
    modport sink (input valid, input result_data, input status,
                  input is_end_of_chain, input is_bad, input free_count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fat_front.sv =====
// Front end: accepts request words, range-checks and classifies them.
// Depends on fat_pkg and fat_in_if.
`default_nettype none
module fat_front
    import fat_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_hold,
    fat_in_if.sink    i_req,
    input  wire logic i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic cluster_ok;
    logic in_table;
    logic accept;

    // Classify the incoming word
    always_comb begin
        cluster_ok = (i_req.cluster_number >= MIN_CLUSTER) &&
                     (i_req.cluster_number <= MAX_CLUSTER);
        in_table = i_req.cluster_number < 32'(TABLE_ENTRIES);
        n_cmd.addr = i_req.cluster_number[AW-1:0];
        n_cmd.value = i_req.entry_value;
        unique case (i_req.mode)
            MODE_READ: begin
                if (!cluster_ok) n_cmd.op = OP_REJECT;
                else if (in_table) n_cmd.op = OP_READ;
                else n_cmd.op = OP_READ_EOC;
            end
            MODE_WRITE: n_cmd.op = (cluster_ok && in_table) ? OP_WRITE : OP_REJECT;
            MODE_ALLOC: n_cmd.op = OP_ALLOC;
            MODE_FREE:  n_cmd.op = (cluster_ok && in_table) ? OP_FREE : OP_REJECT;
            default:    n_cmd.op = OP_REJECT;
        endcase
    end

    // Hand the held command on when the queue has room
    assign o_push = r_valid && !i_full;
    assign o_cmd = r_cmd;
    assign i_req.ready = !i_hold && (!r_valid || o_push);
    assign accept = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/fat_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on fat_pkg.
`default_nettype none
module fat_queue
    import fat_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd           r_slot [QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr;
    logic [QW-1:0]  r_rd_ptr;
    logic [QCW-1:0] r_count;

    assign o_full = r_count == QCW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd = r_slot[r_rd_ptr];

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/fat_back.sv =====
// Back end: owns the allocation table, next-free pointer and free count,
// executes commands and drives the response register. Depends on fat_pkg.
`default_nettype none
module fat_back
    import fat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [27:0] i_cfg_wdata,
    input  wire logic        i_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    output t_back_stat       o_stat,
    fat_out_if.source        o_rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_EMIT
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr_idx;
    logic [27:0]   r_total;
    logic [27:0]   r_count;
    logic [KW-1:0] r_ptr;
    logic [KW-1:0] r_k;

    // Table memory
    logic [31:0]   r_table [TABLE_ENTRIES];
    logic [31:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Pending result and response register
    logic [31:0]   r_res_data;
    t_status       r_res_status;
    logic          r_res_eoc;
    logic          r_res_bad;
    logic          r_out_valid;
    logic [31:0]   r_out_data;
    t_status       r_out_status;
    logic          r_out_eoc;
    logic          r_out_bad;
    logic [27:0]   r_out_count;

    logic scan_ok;
    logic slot_free;

    assign scan_ok = (28'(r_k) <= r_total) && (r_k < KW'(TABLE_ENTRIES));
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign o_pop = (r_state == ST_IDLE) && i_valid;
    assign o_stat.clearing = r_state == ST_CLEAR;
    assign o_stat.idle = r_state == ST_IDLE;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.result_data = r_out_data;
    assign o_rsp.status = r_out_status;
    assign o_rsp.is_end_of_chain = r_out_eoc;
    assign o_rsp.is_bad = r_out_bad;
    assign o_rsp.free_count = r_out_count;

    // Steer the memory ports
    always_comb begin
        mem_we = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = '0;
        mem_raddr = i_cmd.addr;
        unique case (r_state)
            ST_CLEAR: mem_we = 1'b1;
            ST_IDLE: begin
                if (i_valid && i_cmd.op == OP_WRITE) begin
                    mem_we = 1'b1;
                    mem_waddr = i_cmd.addr;
                    mem_wdata = i_cmd.value;
                end else if (i_valid && i_cmd.op == OP_FREE) begin
                    mem_we = 1'b1;
                    mem_waddr = i_cmd.addr;
                end
            end
            ST_SCAN: mem_raddr = r_k[AW-1:0];
            ST_SCAN_CHK: begin
                if (r_rdata == '0) begin
                    mem_we = 1'b1;
                    mem_waddr = r_k[AW-1:0];
                    mem_wdata = EOC_MARK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_table[mem_raddr];
    end

    // Sequence commands, hold table state and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr_idx <= '0;
            r_out_valid <= 1'b0;
            r_total <= RESET_TOTAL;
            r_count <= RESET_TOTAL;
            r_ptr <= KW'(MIN_CLUSTER);
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == AW'(TABLE_ENTRIES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_res_eoc <= 1'b0;
                        r_res_bad <= 1'b0;
                        r_res_data <= '0;
                        r_res_status <= STATUS_OK;
                        r_state <= ST_EMIT;
                        unique case (i_cmd.op)
                            OP_READ: r_state <= ST_RD_WAIT;
                            OP_READ_EOC: begin
                                r_res_data <= EOC_MARK;
                                r_res_eoc <= 1'b1;
                            end
                            OP_WRITE: ;
                            OP_FREE: begin
                                if (r_count != COUNT_MAX) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_ALLOC: begin
                                if (r_count == '0) begin
                                    r_res_data <= NO_VALUE;
                                    r_res_status <= STATUS_FULL;
                                end else begin
                                    // pointer never drops below the first data cluster
                                    r_k <= r_ptr;
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: begin
                                r_res_data <= NO_VALUE;
                                r_res_status <= STATUS_RANGE;
                            end
                        endcase
                    end
                end
                ST_RD_WAIT: begin
                    r_res_data <= r_rdata;
                    r_res_eoc <= (r_rdata >= EOC_LOW) && (r_rdata <= EOC_MARK);
                    r_res_bad <= r_rdata == BAD_MARK;
                    r_state <= ST_EMIT;
                end
                ST_SCAN: begin
                    if (scan_ok) begin
                        r_state <= ST_SCAN_CHK;
                    end else begin
                        r_res_data <= NO_VALUE;
                        r_res_status <= STATUS_FULL;
                        r_state <= ST_EMIT;
                    end
                end
                ST_SCAN_CHK: begin
                    if (r_rdata == '0) begin
                        r_count <= r_count - 1'b1;
                        r_ptr <= r_k + 1'b1;
                        r_res_data <= 32'(r_k);
                        r_state <= ST_EMIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data <= r_res_data;
                        r_out_status <= r_res_status;
                        r_out_eoc <= r_res_eoc;
                        r_out_bad <= r_res_bad;
                        r_out_count <= r_count;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // re-initialize pointer and count on a register write
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
                r_count <= i_cfg_wdata;
                r_ptr <= KW'(MIN_CLUSTER);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/fat_cluster_table_allocator.sv =====
// Words pass through the front register and the command queue to the back end, which
// answers each word in turn: reads wait for the table read, and an allocation examines
// table entries one at a time (with one extra step when the scan runs past its limit).
// The front end can take new words while the back end is busy, as long as the queue has room.
// Reset: synchronous; a clearing pass over all TABLE_ENTRIES (1024) entries zeroes the
// table, during which no request word is accepted (register writes still are).
`default_nettype none
`include "fat_cluster_table_allocator_macros.svh"
module fat_cluster_table_allocator
    import fat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [27:0] i_cfg_wdata,
    fat_in_if.sink           i_req,
    fat_out_if.source        o_rsp
);

    logic       q_push;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    t_cmd       front_cmd;
    t_cmd       q_cmd;
    t_back_stat back_stat;

    // Accept and classify
    fat_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (back_stat.clearing),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (front_cmd)
    );

    // Decouple front and back
    fat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Execute against the table
    fat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_stat      (back_stat),
        .o_rsp       (o_rsp)
    );

    // Checks
    `FAT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> back_stat.clearing, "no clear after reset")
    `FAT_ASSERT(a_no_accept_clear, i_clk, i_rst_n, back_stat.clearing |-> !i_req.ready, "accept while clearing")
    `FAT_ASSERT(a_pop_leaves_idle, i_clk, i_rst_n, back_stat.idle && q_valid |=> !back_stat.idle, "queued word not taken")
    `FAT_ASSERT(a_full_no_value, i_clk, i_rst_n, o_rsp.valid && o_rsp.status == STATUS_FULL |-> o_rsp.result_data == NO_VALUE, "full without no-value")
    `FAT_ASSERT(a_bad_is_ok, i_clk, i_rst_n, o_rsp.valid && o_rsp.is_bad |-> o_rsp.status == STATUS_OK && !o_rsp.is_end_of_chain, "bad flag on failed read")

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for fat_cluster_table_allocator: drives read, write, allocate
// and free words through the request channel and checks every response word.
// Depends on fat_pkg and the fat_in_if / fat_out_if channel interfaces.
`timescale 1ns / 100ps
module testbench;
    import fat_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int BURST_WORDS = 125;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES = 40;

    // One response word as the table should produce it
    typedef struct {
        logic [31:0] data;
        t_status     status;
        logic        eoc;
        logic        bad;
        logic [27:0] count;
    } t_fat_reply;

    // Shadow allocation table; turns each accepted request into its response
    class t_fat_table_tracker;
        logic [31:0] shadow [TABLE_ENTRIES];
        logic [31:0] scan_ptr;
        logic [27:0] free_left;
        logic [27:0] total;
        t_fat_reply  awaited [$];
        int errors;
        int n_reads, n_writes, n_allocs, n_frees, n_full, n_rejects, n_settings;

        function new();
            foreach (shadow[i]) shadow[i] = '0;
            total = RESET_TOTAL;
            free_left = RESET_TOTAL;
            scan_ptr = MIN_CLUSTER;
            n_settings = 1;
        endfunction

        // Re-initialize the counters; table contents are kept
        function void note_config(logic [27:0] value);
            total = value;
            free_left = value;
            scan_ptr = MIN_CLUSTER;
            n_settings++;
        endfunction

        function void note_request(logic [1:0] mode, logic [31:0] cluster,
                                   logic [31:0] value);
            t_fat_reply r;
            logic [31:0] k;
            bit in_range, in_table, hit;
            r.data = NO_VALUE;
            r.status = STATUS_RANGE;
            r.eoc = 1'b0;
            r.bad = 1'b0;
            in_range = cluster >= MIN_CLUSTER && cluster <= MAX_CLUSTER;
            in_table = in_range && cluster < TABLE_ENTRIES;
            case (mode)
                MODE_READ: begin
                    n_reads++;
                    if (in_range) begin
                        r.data = in_table ? shadow[cluster[AW-1:0]] : EOC_MARK;
                        r.status = STATUS_OK;
                        r.eoc = r.data >= EOC_LOW && r.data <= EOC_MARK;
                        r.bad = r.data == BAD_MARK;
                    end
                end
                MODE_WRITE: begin
                    n_writes++;
                    if (in_table) begin
                        shadow[cluster[AW-1:0]] = value;
                        r.data = '0;
                        r.status = STATUS_OK;
                    end
                end
                MODE_ALLOC: begin
                    n_allocs++;
                    r.status = STATUS_FULL;
                    if (free_left != '0) begin
                        // Scan upward from the pointer, no wrap
                        k = (scan_ptr < MIN_CLUSTER) ? MIN_CLUSTER : scan_ptr;
                        hit = 1'b0;
                        while (!hit && k <= {4'd0, total} && k < TABLE_ENTRIES) begin
                            if (shadow[k[AW-1:0]] == '0) begin
                                shadow[k[AW-1:0]] = EOC_MARK;
                                free_left = free_left - 28'd1;
                                scan_ptr = k + 32'd1;
                                r.data = k;
                                r.status = STATUS_OK;
                                hit = 1'b1;
                            end else begin
                                k = k + 32'd1;
                            end
                        end
                    end
                end
                default: begin
                    n_frees++;
                    if (in_table) begin
                        shadow[cluster[AW-1:0]] = '0;
                        if (free_left != COUNT_MAX) free_left = free_left + 28'd1;
                        r.data = '0;
                        r.status = STATUS_OK;
                    end
                end
            endcase
            if (r.status == STATUS_RANGE) n_rejects++;
            if (r.status == STATUS_FULL) n_full++;
            r.count = free_left;
            awaited.push_back(r);
        endfunction

        function void check_response(t_fat_reply got);
            t_fat_reply exp;
            if (awaited.size() == 0) begin
                $display("%0t: response word with nothing outstanding (data %h status %0d)",
                         $time, got.data, got.status);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.data !== exp.data) begin
                $display("%0t: result_data expected %h actual %h", $time, exp.data, got.data);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.eoc !== exp.eoc) begin
                $display("%0t: is_end_of_chain expected %b actual %b", $time, exp.eoc, got.eoc);
                errors++;
            end
            if (got.bad !== exp.bad) begin
                $display("%0t: is_bad expected %b actual %b", $time, exp.bad, got.bad);
                errors++;
            end
            if (got.count !== exp.count) begin
                $display("%0t: free_count expected %h actual %h", $time, exp.count, got.count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [27:0] i_cfg_wdata;
    bit          calm;
    int          quiet_cycles = 0;

    fat_in_if  req_ch ();
    fat_out_if rsp_ch ();

    t_fat_table_tracker tracker = new();

    fat_cluster_table_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Response side: random stalls unless the phase is calm
    initial begin : response_sink
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    // Check each accepted response word
    always @(posedge i_clk) begin
        t_fat_reply got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.data = rsp_ch.result_data;
            got.status = t_status'(rsp_ch.status);
            got.eoc = rsp_ch.is_end_of_chain;
            got.bad = rsp_ch.is_bad;
            got.count = rsp_ch.free_count;
            tracker.check_response(got);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Present one request word and hold it until accepted
    task automatic send_word(logic [1:0] mode, logic [31:0] cluster, logic [31:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.cluster_number <= cluster;
        req_ch.entry_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.note_request(mode, cluster, value);
    endtask

    // Drop valid and wait for every outstanding response word
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_total(logic [27:0] value);
        i_cfg_wdata <= value;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.note_config(value);
    endtask

    // Bias clusters toward the live part of the table, with edges and noise
    function automatic logic [31:0] pick_cluster();
        int r, lim;
        r = $urandom_range(0, 99);
        lim = (tracker.total + 3 < 1027) ? int'(tracker.total) + 3 : 1027;
        if (lim < 12) lim = 12;
        if (r < 6) return $urandom_range(0, 1);
        if (r < 10) return $urandom_range(TABLE_ENTRIES - 4, TABLE_ENTRIES + 3);
        if (r < 12) return MAX_CLUSTER + $urandom_range(0, 1);
        if (r < 14) return $urandom_range(0, 1) ? NO_VALUE : EOC_LOW;
        if (r < 20) return $urandom();
        return $urandom_range(2, lim);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return '0;
        if (r < 45) return EOC_LOW + $urandom_range(0, 7);
        if (r < 52) return BAD_MARK;
        if (r < 60) return $urandom_range(2, TABLE_ENTRIES - 1);
        return $urandom();
    endfunction

    task automatic random_burst(int count, bit squeeze);
        int r;
        logic [1:0] mode;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if (squeeze && n == count / 2) drain_results();
            r = $urandom_range(0, 99);
            mode = (r < 35) ? MODE_ALLOC : (r < 55) ? MODE_FREE :
                   (r < 80) ? MODE_READ : MODE_WRITE;
            send_word(mode, pick_cluster(), pick_value());
        end
    endtask

    initial begin : stimulus
        logic [27:0] settings [8];
        settings = '{28'd0, 28'd40, COUNT_MAX, 28'd12, COUNT_MAX - 28'd1,
                     28'd1500, 28'd0, RESET_TOTAL};
        settings[6] = 28'($urandom_range(16, 1100));
        calm = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_READ;
        req_ch.cluster_number <= '0;
        req_ch.entry_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Range edges, beyond-table reads, marks and rejected words
        send_word(MODE_READ, 32'd0, '0);
        send_word(MODE_READ, 32'd1, '0);
        send_word(MODE_READ, MIN_CLUSTER, '0);
        send_word(MODE_READ, TABLE_ENTRIES - 1, '0);
        send_word(MODE_READ, TABLE_ENTRIES, '0);
        send_word(MODE_READ, MAX_CLUSTER, '0);
        send_word(MODE_READ, MAX_CLUSTER + 32'd1, '0);
        send_word(MODE_READ, NO_VALUE, '0);
        send_word(MODE_WRITE, 32'd5, BAD_MARK);
        send_word(MODE_READ, 32'd5, '0);
        send_word(MODE_WRITE, 32'd6, EOC_LOW);
        send_word(MODE_READ, 32'd6, '0);
        send_word(MODE_WRITE, 32'd7, NO_VALUE);
        send_word(MODE_READ, 32'd7, '0);
        send_word(MODE_WRITE, TABLE_ENTRIES, 32'h1234_5678);
        send_word(MODE_WRITE, 32'd1, 32'h1234_5678);
        send_word(MODE_ALLOC, '0, '0);
        send_word(MODE_ALLOC, NO_VALUE, NO_VALUE);
        send_word(MODE_FREE, 32'd3, '0);
        // Freeing an entry that is already free still bumps the count
        send_word(MODE_FREE, 32'd3, '0);
        send_word(MODE_FREE, TABLE_ENTRIES, '0);
        send_word(MODE_FREE, 32'd0, '0);
        send_word(MODE_WRITE, 32'd9, 32'hAAAA_5555);
        send_word(MODE_WRITE, 32'd10, 32'h5555_AAAA);
        send_word(MODE_ALLOC, '0, '0);

        random_burst(BURST_WORDS, 1'b0);
        // Walk the scan limit through empty, tiny, saturating and oversize volumes
        for (int p = 0; p < 8; p++) begin
            drain_results();
            load_total(settings[p]);
            random_burst(BURST_WORDS, p == 2);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d reads, %0d writes, %0d allocations, %0d frees",
                 tracker.n_reads, tracker.n_writes, tracker.n_allocs, tracker.n_frees);
        $display("  %0d rejected, %0d table-full answers, %0d scan-limit settings",
                 tracker.n_rejects, tracker.n_full, tracker.n_settings);
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
